FILE: sv/software_timer_table_defines.svh
// ----------------------------------------------------------------------------
// software timer table assertion macros
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define STT_ASSERT(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define STT_ASSERT(label, clk, rstn, prop)
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// software timer table package
// shared constants, codes and cell interface structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stt_pkg;

	localparam int NUM_SLOTS = 16;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	typedef enum logic [1:0] {
		KIND_FIRED = 2'd0,
		KIND_ADDED = 2'd1,
		KIND_FULL  = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic        op;
		logic [31:0] now;
		logic [31:0] delay;
		logic [31:0] period;
		logic [7:0]  handle;
		logic        shift;
		logic        flush;
		logic        take;
	} cell_cmd_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] handle;
		logic       tok;
	} cell_stat_t;

endpackage

FILE: sv/stt_cell.sv
// ----------------------------------------------------------------------------
// timer slot cell
// one table slot; a scan token enters from the previous cell and moves on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_cell
	import stt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  logic       tok_in,
	output cell_stat_t stat
);

	logic        tok_q;
	logic        valid_q;
	logic [31:0] expire_q;
	logic [31:0] period_q;
	logic [7:0]  handle_q;
	logic        hit;

	always_comb begin
		if (cmd.op == OP_ADD) begin
			hit = tok_q && !valid_q;
		end else begin
			hit = tok_q && valid_q && (cmd.now >= expire_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.flush) begin
				tok_q <= 1'b0;
			end else if (cmd.shift) begin
				tok_q <= tok_in;
			end
			if (hit && cmd.take) begin
				if (cmd.op == OP_ADD) begin
					valid_q <= 1'b1;
				end else if (period_q == 32'd0) begin
					valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && cmd.take) begin
			if (cmd.op == OP_ADD) begin
				expire_q <= cmd.now + cmd.delay;
				period_q <= cmd.period;
				handle_q <= cmd.handle;
			end else begin
				expire_q <= cmd.now + period_q;
			end
		end
	end

	assign stat.hit    = hit;
	assign stat.handle = handle_q;
	assign stat.tok    = tok_q;

endmodule

FILE: sv/software_timer_table.sv
// ----------------------------------------------------------------------------
// software timer table
// tick counter and a chain of timer slot cells scanned by a walking token
// ----------------------------------------------------------------------------
// a tick registers its done result in ST_DONE after the token leaves the last cell, plus output stalls
// an add registers its result when the token reaches a free slot, else a full result via ST_DONE
// the scan token walks one cell per cycle unless a hit waits on a stalled output; one request is in work at a time
// the next request is taken the cycle after the last result is registered
// so a tick holds the input side until its done result is registered
// arst_n clears the count, all slot valid bits, the token chain and the output valid flag
`timescale 1ns / 1ps
`include "software_timer_table_defines.svh"

module software_timer_table
	import stt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] delay,
	input  logic [31:0] period,
	input  logic [7:0]  handle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  fired_handle,
	output logic [31:0] now,
	output logic        last
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t      state_q;
	logic [31:0] count_q;
	logic        op_q;
	logic [31:0] delay_q;
	logic [31:0] period_q;
	logic [7:0]  handle_q;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  fired_q;
	logic [31:0] now_q;
	logic        last_q;

	cell_cmd_t          cmd;
	cell_stat_t [NUM_SLOTS-1:0] stat;
	logic [NUM_SLOTS:0] tok_chain;
	logic [NUM_SLOTS-1:0] tok_vec;

	logic       accept;
	logic       out_free;
	logic       any_hit;
	logic [7:0] hit_handle;
	logic       scan;
	logic       adv;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign scan     = (state_q == ST_SCAN);

	always_comb begin
		any_hit    = 1'b0;
		hit_handle = 8'd0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			any_hit    = any_hit | stat[i].hit;
			hit_handle = hit_handle | (stat[i].handle & {8{stat[i].hit}});
		end
	end

	assign adv = scan && (any_hit ? ((op_q == OP_TICK) && out_free) : 1'b1);

	assign cmd.op     = op_q;
	assign cmd.now    = count_q;
	assign cmd.delay  = delay_q;
	assign cmd.period = period_q;
	assign cmd.handle = handle_q;
	assign cmd.shift  = adv || accept;
	assign cmd.flush  = scan && any_hit && (op_q == OP_ADD) && out_free;
	assign cmd.take   = scan && out_free;

	assign tok_chain[0] = accept;

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		stt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.tok_in (tok_chain[g]),
			.stat   (stat[g])
		);
		assign tok_chain[g+1] = stat[g].tok;
		assign tok_vec[g]     = stat[g].tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						if (op == OP_TICK) begin
							count_q <= count_q + 32'd1;
						end
					end
				end
				ST_SCAN: begin
					if (any_hit && out_free) begin
						out_valid_q <= 1'b1;
						if (op_q == OP_ADD) begin
							state_q <= ST_IDLE;
						end
					end
					if (adv && tok_chain[NUM_SLOTS]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			delay_q  <= delay;
			period_q <= period;
			handle_q <= handle;
		end
		if (scan && any_hit && out_free) begin
			now_q <= count_q;
			if (op_q == OP_ADD) begin
				kind_q  <= KIND_ADDED;
				fired_q <= 8'd0;
				last_q  <= 1'b1;
			end else begin
				kind_q  <= KIND_FIRED;
				fired_q <= hit_handle;
				last_q  <= 1'b0;
			end
		end else if ((state_q == ST_DONE) && out_free) begin
			now_q   <= count_q;
			kind_q  <= (op_q == OP_ADD) ? KIND_FULL : KIND_DONE;
			fired_q <= 8'd0;
			last_q  <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign fired_handle = fired_q;
	assign now          = now_q;
	assign last         = last_q;

	`STT_ASSERT(a_tok_onehot, clk, arst_n, $onehot0(tok_vec))
	`STT_ASSERT(a_tok_scan, clk, arst_n, (tok_vec == '0) || (state_q == ST_SCAN))
	`STT_ASSERT(a_done_empty, clk, arst_n, (state_q != ST_DONE) || (tok_vec == '0))
	`STT_ASSERT_NEXT(a_add_ends, clk, arst_n, scan && any_hit && (op_q == OP_ADD) && out_free,
		(state_q == ST_IDLE) && out_valid_q)

endmodule
